@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, muted in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nlst_pkg.sv @@
// ---------------------------------------------------------------------------
// nlst_pkg
// Types and codes shared by the nested length section tracker.
// ---------------------------------------------------------------------------
package nlst_pkg;

  localparam int MaxDepthDefault = 8;
  localparam int LenW = 32;

  // Operation codes
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_BEGIN   = 2'd1;
  localparam logic [1:0] OP_CONSUME = 2'd2;
  localparam logic [1:0] OP_END     = 2'd3;

  // Status codes
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_TOO_DEEP   = 3'd1;
  localparam logic [2:0] STAT_UNDERFLOW  = 3'd2;
  localparam logic [2:0] STAT_NONE_OPEN  = 3'd3;
  localparam logic [2:0] STAT_BYTES_LEFT = 3'd4;

  typedef struct packed {
    logic [1:0]      op;
    logic [LenW-1:0] length;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       all_closed;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONSUME,
    S_END
  } state_t;

endpackage

@@ rtl/nlst_count_mem.sv @@
// ---------------------------------------------------------------------------
// nlst_count_mem
// Remaining-count store: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module nlst_count_mem #(
  parameter int MAX_DEPTH = nlst_pkg::MaxDepthDefault,
  parameter int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [nlst_pkg::LenW-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic [nlst_pkg::LenW-1:0] rdata
);

  logic [nlst_pkg::LenW-1:0] mem [MAX_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read returns old contents on a same-address collision; the sequencer
  // never uses a read of the entry it writes in the same cycle.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/nlst_seq.sv @@
// ---------------------------------------------------------------------------
// nlst_seq
// Sequencer: level count, consume walk, end check and result register.
// ---------------------------------------------------------------------------
module nlst_seq #(
  parameter int MAX_DEPTH = nlst_pkg::MaxDepthDefault,
  parameter int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
  parameter int LW = $clog2(MAX_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  nlst_pkg::in_item_t        item,
  output logic                      done,
  output nlst_pkg::out_item_t       result,
  output logic                      we,
  output logic [AW-1:0]             waddr,
  output logic [nlst_pkg::LenW-1:0] wdata,
  output logic [AW-1:0]             raddr,
  input  logic [nlst_pkg::LenW-1:0] rdata
);

  nlst_pkg::state_t          state, state_next;
  logic [LW-1:0]             open_levels, open_levels_next;
  logic [AW-1:0]             idx, idx_next;
  logic [nlst_pkg::LenW-1:0] len, len_next;
  logic                      done_next;
  logic [2:0]                status_next;
  logic                      accept;
  logic [LW-1:0]             idx_inc;
  logic [LW-1:0]             top;
  logic                      short;

  assign busy    = (state != nlst_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign idx_inc = LW'(idx) + LW'(1);
  assign top     = open_levels - LW'(1);
  assign short   = (rdata < len);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      nlst_pkg::S_IDLE: begin
        if (accept && open_levels != '0) begin
          if (item.op == nlst_pkg::OP_CONSUME) begin
            state_next = nlst_pkg::S_CONSUME;
          end else if (item.op == nlst_pkg::OP_END) begin
            state_next = nlst_pkg::S_END;
          end
        end
      end
      nlst_pkg::S_CONSUME: begin
        if (short || idx_inc >= open_levels) begin
          state_next = nlst_pkg::S_IDLE;
        end
      end
      nlst_pkg::S_END: begin
        state_next = nlst_pkg::S_IDLE;
      end
      default: begin
        state_next = nlst_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and memory control
  always_comb begin
    we               = 1'b0;
    waddr            = idx;
    wdata            = rdata - len;
    raddr            = '0;
    open_levels_next = open_levels;
    idx_next         = idx;
    len_next         = len;
    done_next        = 1'b0;
    status_next      = nlst_pkg::STAT_OK;
    case (state)
      nlst_pkg::S_IDLE: begin
        if (accept) begin
          len_next = item.length;
          case (item.op)
            nlst_pkg::OP_CLEAR: begin
              open_levels_next = '0;
              done_next        = 1'b1;
            end
            nlst_pkg::OP_BEGIN: begin
              done_next = 1'b1;
              if (open_levels >= LW'(MAX_DEPTH)) begin
                status_next = nlst_pkg::STAT_TOO_DEEP;
              end else begin
                we               = 1'b1;
                waddr            = open_levels[AW-1:0];
                wdata            = item.length;
                open_levels_next = open_levels + LW'(1);
              end
            end
            nlst_pkg::OP_CONSUME: begin
              raddr    = '0;
              idx_next = '0;
              if (open_levels == '0) begin
                done_next = 1'b1;
              end
            end
            nlst_pkg::OP_END: begin
              raddr = top[AW-1:0];
              if (open_levels == '0) begin
                done_next   = 1'b1;
                status_next = nlst_pkg::STAT_NONE_OPEN;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      nlst_pkg::S_CONSUME: begin
        if (short) begin
          done_next   = 1'b1;
          status_next = nlst_pkg::STAT_UNDERFLOW;
        end else begin
          we = 1'b1;
          if (idx_inc < open_levels) begin
            raddr    = idx_inc[AW-1:0];
            idx_next = idx_inc[AW-1:0];
          end else begin
            done_next = 1'b1;
          end
        end
      end
      nlst_pkg::S_END: begin
        done_next = 1'b1;
        if (rdata != '0) begin
          status_next = nlst_pkg::STAT_BYTES_LEFT;
        end else begin
          open_levels_next = top;
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= nlst_pkg::S_IDLE;
      open_levels <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      open_levels <= open_levels_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    len <= len_next;
    if (done_next) begin
      result.status     <= status_next;
      result.all_closed <= (open_levels_next == '0);
    end
  end

endmodule

@@ rtl/nested_length_section_tracker.sv @@
// ---------------------------------------------------------------------------
// nested_length_section_tracker
// Clear, begin and ops on an empty stack are answered from the idle state; end
// reads the top level, then checks it; consume walks the levels, one level per
// cycle through the single read port. The next item can be taken in the cycle
// its result strobes; no new item is taken while a walk or end check is busy.
// Reset clears the level count and control; the count memory is not cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nested_length_section_tracker #(
  parameter int MAX_DEPTH = nlst_pkg::MaxDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  nlst_pkg::in_item_t  item,
  output logic                done,
  output nlst_pkg::out_item_t result
);

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LW = $clog2(MAX_DEPTH + 1);

  // Memory port between sequencer and count store.
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [nlst_pkg::LenW-1:0] wdata;
  logic [AW-1:0]             raddr;
  logic [nlst_pkg::LenW-1:0] rdata;

  // Sequencer: holds the open-level count in flops and walks the stack
  // through the memory. A consume reads level 0, then each cycle checks
  // the returned count, writes it back decremented and reads the next
  // level. A read of the entry written that cycle is never used, so no forwarding.
  nlst_seq #(
    .MAX_DEPTH (MAX_DEPTH),
    .AW        (AW),
    .LW        (LW)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rdata  (rdata)
  );

  // Count store: entries below the open-level count are valid, and begin
  // writes each before it is read, so the store needs no clearing.
  nlst_count_mem #(
    .MAX_DEPTH (MAX_DEPTH),
    .AW        (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // A result always lands after the walk has finished.
  `ASSERT_PROP(a_done_idle, !done || !busy, "result strobe while busy")

  // Writes stay inside the store.
  `ASSERT_PROP(a_waddr_range, !we || (int'(waddr) < MAX_DEPTH), "write beyond depth")

  // Clear answers in the next cycle with ok and an empty stack.
  `ASSERT_NEXT(a_clear, start && !busy && item.op == nlst_pkg::OP_CLEAR,
               done && result.all_closed && result.status == nlst_pkg::STAT_OK,
               "clear result wrong")

endmodule
